[src/e2r_pkg.sv]
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared types, constants and fixed-point helpers for the Euler-to-matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package e2r_pkg;

	localparam int IN_W          = 15;
	localparam int OUT_W_DEF     = 16;
	localparam int ANGLE_W_DEF   = 16;
	localparam int STAGES_DEF    = 14;
	localparam int HALF_PI_Q12   = 6434;
	localparam int PI_Q12        = 12868;
	localparam longint GAIN_Q30  = 64'd652032874;

	typedef logic signed [IN_W-1:0] angle_t;

	// atan(2^-i) at scale 2^30
	function automatic logic [31:0] atan_q30(input int idx);
		logic [31:0] r;
		begin
			case (idx)
				0:  r = 32'h3243F6A8;
				1:  r = 32'h1DAC6705;
				2:  r = 32'h0FADBAFC;
				3:  r = 32'h07F56EA6;
				4:  r = 32'h03FEAB76;
				5:  r = 32'h01FFD55B;
				6:  r = 32'h00FFFAAA;
				7:  r = 32'h007FFF55;
				8:  r = 32'h003FFFEA;
				9:  r = 32'h001FFFFD;
				10: r = 32'h000FFFFF;
				11: r = 32'h0007FFFF;
				12: r = 32'h0003FFFF;
				13: r = 32'h0001FFFF;
				14: r = 32'h0000FFFF;
				15: r = 32'h00007FFF;
				16: r = 32'h00003FFF;
				17: r = 32'h00001FFF;
				18: r = 32'h00000FFF;
				19: r = 32'h000007FF;
				20: r = 32'h000003FF;
				21: r = 32'h000001FF;
				22: r = 32'h000000FF;
				23: r = 32'h0000007F;
				24: r = 32'h0000003F;
				25: r = 32'h0000001F;
				26: r = 32'h0000000F;
				27: r = 32'h00000008;
				28: r = 32'h00000004;
				29: r = 32'h00000002;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

[src/e2r_if.sv]
// ----------------------------------------------------------------------------
// e2r_in_if / e2r_out_if
// Valid/ready channels carrying the angle triple and the nine matrix entries.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2r_in_if;
	logic                  valid;
	logic                  ready;
	logic signed [14:0]    pitch_angle;
	logic signed [14:0]    yaw_angle;
	logic signed [14:0]    roll_angle;
	modport source (output valid, pitch_angle, yaw_angle, roll_angle, input ready);
	modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

interface e2r_out_if #(parameter int OUT_BITS = 16);
	logic                      valid;
	logic                      ready;
	logic signed [OUT_BITS-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

`default_nettype wire

[src/e2r_cordic.sv]
// ----------------------------------------------------------------------------
// e2r_cordic
// Pipelined rotation-mode CORDIC: range reduction, one register per iteration,
// saturation and sign flip. Advances when en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_cordic #(
	parameter int ANGLE_BITS    = e2r_pkg::ANGLE_W_DEF,
	parameter int OUT_BITS      = e2r_pkg::OUT_W_DEF,
	parameter int CORDIC_STAGES = e2r_pkg::STAGES_DEF
) (
	input  wire                        clk,
	input  wire                        en,
	input  wire signed [14:0]          angle,
	output logic signed [OUT_BITS-1:0] sin_val,
	output logic signed [OUT_BITS-1:0] cos_val
);
	localparam int AF = ANGLE_BITS - 2;
	localparam int OF = OUT_BITS - 2;
	localparam int N  = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
	localparam int ZW = ANGLE_BITS + 3;
	localparam int XW = OUT_BITS + 2;
	localparam longint GAIN_RND = (OF < 30) ? (longint'(1) <<< (29 - OF)) : 0;
	localparam longint X0 = (e2r_pkg::GAIN_Q30 + GAIN_RND) >>> (30 - OF);
	localparam logic signed [XW-1:0] ONE  = XW'(longint'(1) <<< OF);
	localparam logic signed [XW-1:0] MONE = -ONE;

	logic signed [15:0]  red;
	logic                flip;
	logic signed [ZW-1:0] z0;

	logic signed [ZW-1:0] z_s [0:N];
	logic signed [XW-1:0] x_s [0:N];
	logic signed [XW-1:0] y_s [0:N];
	logic                 flip_s [0:N];

	always_comb begin
		red  = 16'(angle);
		flip = 1'b0;
		if (angle > 15'(e2r_pkg::HALF_PI_Q12)) begin
			red  = 16'(angle) - 16'(e2r_pkg::PI_Q12);
			flip = 1'b1;
		end else if (angle < -15'sd6434) begin
			red  = 16'(angle) + 16'(e2r_pkg::PI_Q12);
			flip = 1'b1;
		end
		if (AF >= 12)
			z0 = ZW'(red) <<< ((AF >= 12) ? (AF - 12) : 0);
		else
			z0 = ZW'(red) >>> ((AF < 12) ? (12 - AF) : 0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0]    <= z0;
			x_s[0]    <= XW'(X0);
			y_s[0]    <= '0;
			flip_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam longint T = (AF >= 30) ? longint'(e2r_pkg::atan_q30(i)) :
			((longint'(e2r_pkg::atan_q30(i)) + (longint'(1) <<< (29 - AF)))
			>>> (30 - AF));
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ZW'(T);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ZW'(T);
				end
			end
		end
	end

	logic signed [XW-1:0] xs, ys;
	always_comb begin
		xs = (x_s[N] > ONE) ? ONE : ((x_s[N] < MONE) ? MONE : x_s[N]);
		ys = (y_s[N] > ONE) ? ONE : ((y_s[N] < MONE) ? MONE : y_s[N]);
		if (flip_s[N]) begin
			xs = -xs;
			ys = -ys;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= OUT_BITS'(ys);
			cos_val <= OUT_BITS'(xs);
		end
	end
endmodule

`default_nettype wire

[src/e2r_matrix.sv]
// ----------------------------------------------------------------------------
// e2r_matrix
// Product pipeline: sines and cosines in, nine saturated entries out.
// Five register stages: pair products, triple products, rows 0/1, row-2 products,
// row 2.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_matrix #(
	parameter int OUT_BITS = e2r_pkg::OUT_W_DEF
) (
	input  wire                        clk,
	input  wire                        en,
	input  wire signed [OUT_BITS-1:0]  sa, ca, sb, cb, sc, cc,
	output logic signed [OUT_BITS-1:0] m [0:8]
);
	localparam int OF = OUT_BITS - 2;
	localparam int W  = OUT_BITS;
	localparam int PW = 2 * W + 1;
	localparam int SW = W + 3;

	function automatic logic signed [SW-1:0] fmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [PW-1:0] p;
		begin
			p = PW'(a) * PW'(b) + (PW'(1) <<< (OF - 1));
			return SW'(p >>> OF);
		end
	endfunction

	function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] one;
		begin
			one = SW'(1) <<< OF;
			if (v > one) return W'(one);
			if (v < -one) return W'(-one);
			return W'(v);
		end
	endfunction

	// stage 1: first products
	logic signed [W-1:0]  sasb_s1, cc_s1, sc_s1, sb_s1;
	logic signed [SW-1:0] cbcc_s1, cbsc_s1, casc_s1, cacc_s1, sacb_s1;
	// stage 2: triple products
	logic signed [SW-1:0] cbcc_s2, cbsc_s2, casc_s2, cacc_s2, sacb_s2, t3_s2, t4_s2;
	logic signed [W-1:0]  sb_s2;
	// stage 3: rows 0 and 1
	logic signed [W-1:0]  r_s3 [0:5];
	// stage 4: row-2 products
	logic signed [W-1:0]  r_s4 [0:5];
	logic signed [SW-1:0] p_s4 [0:5];

	always_ff @(posedge clk) begin
		if (en) begin
			sasb_s1 <= sat(fmul(sa, sb));
			cc_s1   <= cc;
			sc_s1   <= sc;
			sb_s1   <= sb;
			cbcc_s1 <= fmul(cb, cc);
			cbsc_s1 <= fmul(cb, sc);
			casc_s1 <= fmul(ca, sc);
			cacc_s1 <= fmul(ca, cc);
			sacb_s1 <= fmul(sa, cb);

			cbcc_s2 <= cbcc_s1;
			cbsc_s2 <= cbsc_s1;
			casc_s2 <= casc_s1;
			cacc_s2 <= cacc_s1;
			sacb_s2 <= sacb_s1;
			sb_s2   <= sb_s1;
			t3_s2   <= fmul(sasb_s1, cc_s1);
			t4_s2   <= fmul(sasb_s1, sc_s1);

			r_s3[0] <= sat(cbcc_s2);
			r_s3[1] <= sat(-cbsc_s2);
			r_s3[2] <= sb_s2;
			r_s3[3] <= sat(casc_s2 + t3_s2);
			r_s3[4] <= sat(cacc_s2 - t4_s2);
			r_s3[5] <= sat(-sacb_s2);

			r_s4    <= r_s3;
			p_s4[0] <= fmul(r_s3[1], r_s3[5]);
			p_s4[1] <= fmul(r_s3[2], r_s3[4]);
			p_s4[2] <= fmul(r_s3[2], r_s3[3]);
			p_s4[3] <= fmul(r_s3[0], r_s3[5]);
			p_s4[4] <= fmul(r_s3[0], r_s3[4]);
			p_s4[5] <= fmul(r_s3[1], r_s3[3]);

			for (int k = 0; k < 6; k++)
				m[k] <= r_s4[k];
			m[6] <= sat(p_s4[0] - p_s4[1]);
			m[7] <= sat(p_s4[2] - p_s4[3]);
			m[8] <= sat(p_s4[4] - p_s4[5]);
		end
	end
	// sasb is saturated only in width; fmul of two values within +-1 stays within +-1
endmodule

`default_nettype wire

[src/euler_to_rotation_matrix.sv]
// Throughput: one beat per cycle while the output is not stalled;
// the whole datapath is one stalling pipeline.
// A stall on the output freezes every stage, so nothing is lost or repeated.
// Reset (arst_n, asynchronous, active low) clears only the valid bits;
// the data registers hold whatever they last carried.
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Pitch/yaw/roll angles in Q3.12 to a 3x3 rotation matrix in Q2.(OUT_BITS-2).
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_rotation_matrix #(
	parameter int ANGLE_BITS    = e2r_pkg::ANGLE_W_DEF,
	parameter int OUT_BITS      = e2r_pkg::OUT_W_DEF,
	parameter int CORDIC_STAGES = e2r_pkg::STAGES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	e2r_in_if.sink     in_ch,
	e2r_out_if.source  out_ch
);
	// CORDIC: entry register, one per iteration, output register.
	localparam int NIT = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
	// Matrix pipeline adds five more.
	localparam int LAT = NIT + 7;

	// Whole pipe advances unless the output holds an untaken beat.
	logic en;
	logic [LAT-1:0] vld_q;

	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign out_ch.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	logic signed [OUT_BITS-1:0] sa, ca, sb, cb, sc, cc;

	e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_BITS(OUT_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_a (
		.clk(clk), .en(en), .angle(in_ch.pitch_angle), .sin_val(sa), .cos_val(ca));
	e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_BITS(OUT_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_b (
		.clk(clk), .en(en), .angle(in_ch.yaw_angle), .sin_val(sb), .cos_val(cb));
	e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_BITS(OUT_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_c (
		.clk(clk), .en(en), .angle(in_ch.roll_angle), .sin_val(sc), .cos_val(cc));

	logic signed [OUT_BITS-1:0] m [0:8];

	e2r_matrix #(.OUT_BITS(OUT_BITS)) u_matrix (
		.clk(clk), .en(en), .sa(sa), .ca(ca), .sb(sb), .cb(cb), .sc(sc), .cc(cc),
		.m(m));

	assign out_ch.m00 = m[0];
	assign out_ch.m01 = m[1];
	assign out_ch.m02 = m[2];
	assign out_ch.m10 = m[3];
	assign out_ch.m11 = m[4];
	assign out_ch.m12 = m[5];
	assign out_ch.m20 = m[6];
	assign out_ch.m21 = m[7];
	assign out_ch.m22 = m[8];

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q)) else $error("valid chain moved during stall");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[LAT-1] |-> in_ch.ready) else $error("ready low with empty output");
	a_m02_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.m02 <= (1 <<< (OUT_BITS-2)))
		&& (out_ch.m02 >= -(1 <<< (OUT_BITS-2)))) else $error("m02 beyond one");
`endif
endmodule

`default_nettype wire
